// File: hw/rtl/reeu_pkg.sv
// ----------------------------------------------------------------------------
// reeu_pkg
// Shared types, codes and the quadrature step table of the encoder event unit.
// ----------------------------------------------------------------------------
package reeu_pkg;

  // item operations
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_LONG      = 2'd1;
  localparam logic [1:0] CFG_GAP       = 2'd2;
  localparam logic [1:0] CFG_LOCKOUT   = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_CW     = 3'd1;
  localparam logic [2:0] EV_CCW    = 3'd2;
  localparam logic [2:0] EV_CLICK1 = 3'd3;
  localparam logic [2:0] EV_LONG   = 3'd6;
  localparam logic [2:0] EV_BACK   = 3'd7;

  // reset values of the timing registers
  localparam logic [15:0] DEBOUNCE_RST = 16'd25;
  localparam logic [15:0] LONG_RST     = 16'd700;
  localparam logic [15:0] GAP_RST      = 16'd300;
  localparam logic [15:0] LOCKOUT_RST  = 16'd50;

  // both pins high after reset
  localparam logic [1:0] AB_RST = 2'b11;

  // number of events one update can raise: rotation, button, back
  localparam int NUM_SRC = 3;

  typedef struct packed {
    logic       v;
    logic [2:0] code;
  } ev_t;

  typedef struct packed {
    logic [15:0] db_ms;
    logic [15:0] hold_ms;
    logic [15:0] gap_ms;
    logic [15:0] back_lockout_ms;
  } cfg_t;

  // quarter-step delta from {previous ab, current ab}
  function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/reeu_quad.sv
// ----------------------------------------------------------------------------
// reeu_quad
// Quadrature decode into a saturating quarter-step count, and detent events.
// ----------------------------------------------------------------------------
module reeu_quad (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          smp_go,
  input  logic          upd_go,
  input  logic          pin_a,
  input  logic          pin_b,
  output reeu_pkg::ev_t rot_ev
);
  import reeu_pkg::*;

  logic [1:0]         prev_ab_r;
  logic signed [15:0] qsteps_r;
  logic signed [15:0] qsteps_nxt;
  logic signed [16:0] sum;
  logic signed [15:0] sat_sum;
  logic signed [15:0] rem;
  logic               detent;

  // saturating add of the step delta
  always_comb begin
    sum = 17'(qsteps_r) + 17'(step_delta({prev_ab_r, pin_a, pin_b}));
    if (sum[16] != sum[15]) begin
      sat_sum = sum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_sum = sum[15:0];
    end
  end

  // detent when the magnitude reaches four, keep truncating remainder
  always_comb begin
    detent = (qsteps_r >= 16'sd4) || (qsteps_r <= -16'sd4);
    rem    = (qsteps_r[1:0] == 2'b00) ? 16'sd0 : {{14{qsteps_r[15]}}, qsteps_r[1:0]};
    rot_ev.v    = upd_go && detent;
    rot_ev.code = qsteps_r[15] ? EV_CCW : EV_CW;
  end

  always_comb begin
    qsteps_nxt = qsteps_r;
    if (smp_go) begin
      qsteps_nxt = sat_sum;
    end else if (upd_go && detent) begin
      qsteps_nxt = rem;
    end
  end

  // count and pin history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= AB_RST;
      qsteps_r  <= '0;
    end else begin
      qsteps_r <= qsteps_nxt;
      if (smp_go) begin
        prev_ab_r <= {pin_a, pin_b};
      end
    end
  end

endmodule

// File: hw/rtl/reeu_button.sv
// ----------------------------------------------------------------------------
// reeu_button
// Switch debounce, click / long press machine and back button edge lockout.
// ----------------------------------------------------------------------------
module reeu_button (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd_go,
  input  logic           switch_level,
  input  logic           back_level,
  input  logic [31:0]    now_ms,
  input  reeu_pkg::cfg_t cfg,
  output reeu_pkg::ev_t  btn_ev,
  output reeu_pkg::ev_t  back_ev
);
  import reeu_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAIT    = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        raw_stable_r;
  logic [31:0] db_start_r, db_start_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] release_time_r, release_time_nxt;
  logic        long_done_r, long_done_nxt;
  logic [1:0]  click_cnt_r, click_cnt_nxt;
  logic        last_back_r;
  logic [31:0] last_back_time_r;
  logic        raw_now;
  logic        pressed;
  logic        long_hit;
  logic        gap_hit;
  logic        back_hit;
  logic [31:0] db_elapsed;
  logic [31:0] hold_elapsed;
  logic [31:0] gap_elapsed;
  logic [31:0] back_elapsed;

  // debounce: restart the timer on any change of the raw level
  always_comb begin
    raw_now      = !switch_level;
    db_start_nxt = (raw_now != raw_stable_r) ? now_ms : db_start_r;
    db_elapsed   = now_ms - db_start_nxt;
    pressed      = raw_now && (db_elapsed >= 32'(cfg.db_ms));
    hold_elapsed = now_ms - press_start_r;
    gap_elapsed  = now_ms - release_time_r;
    long_hit     = hold_elapsed >= 32'(cfg.hold_ms);
    gap_hit      = gap_elapsed >= 32'(cfg.gap_ms);
  end

  // button phase machine
  always_comb begin
    phase_nxt        = phase_r;
    press_start_nxt  = press_start_r;
    release_time_nxt = release_time_r;
    long_done_nxt    = long_done_r;
    click_cnt_nxt    = click_cnt_r;
    btn_ev.v         = 1'b0;
    btn_ev.code      = EV_LONG;
    unique case (phase_r)
      PH_PRESSED: begin
        if (!pressed) begin
          if (!long_done_r) begin
            if (click_cnt_r != 2'd3) begin
              click_cnt_nxt = click_cnt_r + 2'd1;
            end
            release_time_nxt = now_ms;
            phase_nxt        = PH_WAIT;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else if (!long_done_r && long_hit) begin
          long_done_nxt = 1'b1;
          click_cnt_nxt = 2'd0;
          btn_ev.v      = 1'b1;
        end
      end
      PH_WAIT: begin
        // gap expired: report the collected clicks
        if (gap_hit) begin
          btn_ev.v      = (click_cnt_r != 2'd0);
          btn_ev.code   = EV_CLICK1 + 3'(click_cnt_r) - 3'd1;
          click_cnt_nxt = 2'd0;
        end
        if (pressed) begin
          phase_nxt       = PH_PRESSED;
          press_start_nxt = now_ms;
          long_done_nxt   = 1'b0;
        end else if (gap_hit) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (pressed) begin
          phase_nxt       = PH_PRESSED;
          press_start_nxt = now_ms;
          long_done_nxt   = 1'b0;
        end
      end
    endcase
    btn_ev.v = btn_ev.v && upd_go;
  end

  // back button falling edge outside the lockout window
  always_comb begin
    back_elapsed = now_ms - last_back_time_r;
    back_hit     = last_back_r && !back_level && (back_elapsed > 32'(cfg.back_lockout_ms));
    back_ev.v    = upd_go && back_hit;
    back_ev.code = EV_BACK;
  end

  // state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      raw_stable_r     <= 1'b0;
      db_start_r       <= '0;
      press_start_r    <= '0;
      release_time_r   <= '0;
      long_done_r      <= 1'b0;
      click_cnt_r      <= '0;
      last_back_r      <= 1'b1;
      last_back_time_r <= '0;
    end else if (upd_go) begin
      phase_r        <= phase_nxt;
      raw_stable_r   <= raw_now;
      db_start_r     <= db_start_nxt;
      press_start_r  <= press_start_nxt;
      release_time_r <= release_time_nxt;
      long_done_r    <= long_done_nxt;
      click_cnt_r    <= click_cnt_nxt;
      last_back_r    <= back_level;
      if (back_hit) begin
        last_back_time_r <= now_ms;
      end
    end
  end

endmodule

// File: hw/rtl/reeu_queue.sv
// ----------------------------------------------------------------------------
// reeu_queue
// Event ring with drop-when-full, a small pending buffer for multi-event
// updates, and the registered poll result.
// ----------------------------------------------------------------------------
module reeu_queue #(
  parameter int QUEUE_SIZE = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd_go,
  input  reeu_pkg::ev_t [reeu_pkg::NUM_SRC-1:0] ev_in,
  input  logic                              pop_go,
  input  logic                              out_stall,
  output logic                              pend_busy,
  output logic                              out_free,
  output logic                              out_valid,
  output logic [2:0]                        out_event_code
);
  import reeu_pkg::*;

  localparam int PW = $clog2(QUEUE_SIZE);

  logic [2:0]           ring [QUEUE_SIZE];
  logic [PW-1:0]        head_r, tail_r;
  logic [PW-1:0]        head_inc, tail_inc;
  ev_t [NUM_SRC-1:0]    pend_r;
  ev_t [NUM_SRC-1:0]    src;
  ev_t [NUM_SRC-1:0]    rest;
  logic                 wr_v;
  logic [2:0]           wr_code;
  logic                 full;
  logic                 empty;
  logic                 out_valid_r;
  logic [2:0]           out_code_r;

  // pointer wrap at any queue size
  always_comb begin
    head_inc = (head_r == PW'(QUEUE_SIZE - 1)) ? '0 : head_r + 1'b1;
    tail_inc = (tail_r == PW'(QUEUE_SIZE - 1)) ? '0 : tail_r + 1'b1;
    full     = (tail_inc == head_r);
    empty    = (head_r == tail_r);
  end

  // pick the oldest event, park the rest
  always_comb begin
    pend_busy = 1'b0;
    for (int i = 0; i < NUM_SRC; i++) begin
      pend_busy = pend_busy | pend_r[i].v;
    end
    src     = pend_busy ? pend_r : (upd_go ? ev_in : '0);
    rest    = src;
    wr_v    = 1'b0;
    wr_code = EV_NONE;
    for (int i = 0; i < NUM_SRC; i++) begin
      if (!wr_v && src[i].v) begin
        wr_v      = 1'b1;
        wr_code   = src[i].code;
        rest[i].v = 1'b0;
      end
    end
  end

  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  // ring storage and registered read
  always_ff @(posedge clk) begin
    if (wr_v && !full) begin
      ring[tail_r] <= wr_code;
    end
    if (pop_go) begin
      out_code_r <= empty ? EV_NONE : ring[head_r];
    end
  end

  // pointers, pending buffer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= rest;
      if (wr_v && !full) begin
        tail_r <= tail_inc;
      end
      if (pop_go) begin
        out_valid_r <= 1'b1;
        if (!empty) begin
          head_r <= head_inc;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a poll never runs while parked events are still going in
  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_busy |-> !pop_go)
    else $error("poll taken while events pending");

  // a poll always leaves a result behind
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop_go |=> out_valid_r)
    else $error("poll produced no result");

  // a write into a full ring is dropped
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_v && full) |=> $stable(tail_r))
    else $error("tail moved on a full ring");

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= PW'(QUEUE_SIZE - 1)) && (tail_r <= PW'(QUEUE_SIZE - 1)))
    else $error("ring pointer out of range");

endmodule

// File: hw/rtl/rotary_encoder_event_unit_top.sv
// A poll item waits in the input register, then its result is registered.
// Throughput: one item per cycle while nothing stalls; an update that raises two or
// three events holds further input until all are written (one ring write a cycle).
// A result waiting on out_stall holds further polls and every item behind them.
// Reset (rst_n, synchronous, active low) clears all control state and sets the
// timing registers to 25, 700, 300 and 50 ms; the ring contents are not cleared.
// ----------------------------------------------------------------------------
// rotary_encoder_event_unit_top
// Quadrature decoder with push switch clicks, long press and back button,
// feeding a polled event ring.
// ----------------------------------------------------------------------------
module rotary_encoder_event_unit_top #(
  parameter int QUEUE_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic        in_pin_a,
  input  logic        in_pin_b,
  input  logic        in_switch_level,
  input  logic        in_back_level,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_code
);
  import reeu_pkg::*;

  cfg_t        cfg_r;
  logic        in_v_r;
  logic [1:0]  op_r;
  logic        pin_a_r;
  logic        pin_b_r;
  logic        sw_r;
  logic        back_r;
  logic [31:0] now_r;
  logic        go;
  logic        smp_go;
  logic        upd_go;
  logic        pop_go;
  logic        pend_busy;
  logic        out_free;
  ev_t         rot_ev;
  ev_t         btn_ev;
  ev_t         back_ev;
  ev_t [NUM_SRC-1:0] ev_all;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.db_ms           <= DEBOUNCE_RST;
      cfg_r.hold_ms         <= LONG_RST;
      cfg_r.gap_ms          <= GAP_RST;
      cfg_r.back_lockout_ms <= LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_r.db_ms           <= cfg_wdata;
        CFG_LONG:     cfg_r.hold_ms         <= cfg_wdata;
        CFG_GAP:      cfg_r.gap_ms          <= cfg_wdata;
        CFG_LOCKOUT:  cfg_r.back_lockout_ms <= cfg_wdata;
      endcase
    end
  end

  // item in the input register proceeds unless events are parked or a poll lacks room
  always_comb begin
    go       = in_v_r && !pend_busy && ((op_r != OP_POLL) || out_free);
    smp_go   = go && (op_r == OP_SAMPLE);
    upd_go   = go && (op_r == OP_UPDATE);
    pop_go   = go && (op_r == OP_POLL);
    in_stall = in_v_r && !go;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_operation;
      pin_a_r <= in_pin_a;
      pin_b_r <= in_pin_b;
      sw_r    <= in_switch_level;
      back_r  <= in_back_level;
      now_r   <= in_now_ms;
    end
  end

  reeu_quad u_quad (
    .clk    (clk),
    .rst_n  (rst_n),
    .smp_go (smp_go),
    .upd_go (upd_go),
    .pin_a  (pin_a_r),
    .pin_b  (pin_b_r),
    .rot_ev (rot_ev)
  );

  reeu_button u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd_go       (upd_go),
    .switch_level (sw_r),
    .back_level   (back_r),
    .now_ms       (now_r),
    .cfg          (cfg_r),
    .btn_ev       (btn_ev),
    .back_ev      (back_ev)
  );

  // queue order within one update: rotation, button, back
  assign ev_all = {back_ev, btn_ev, rot_ev};

  reeu_queue #(
    .QUEUE_SIZE (QUEUE_SIZE)
  ) u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd_go         (upd_go),
    .ev_in          (ev_all),
    .pop_go         (pop_go),
    .out_stall      (out_stall),
    .pend_busy      (pend_busy),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_event_code (out_event_code)
  );

endmodule

// File: test/tb_rotary_encoder_event_unit_top.sv
// ----------------------------------------------------------------------------
// tb_rotary_encoder_event_unit_top
// Self-checking bench for the encoder event unit: drives quadrature samples,
// update ticks and polls under random idling and stalls, keeps its own model
// of the decoder, button machine, back button and event ring, and compares
// every polled event code with the predicted one.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_event_unit_top;
  timeunit 1ns;
  timeprecision 1ps;
  import reeu_pkg::*;

  // prediction of the block state and of the event codes that polls return
  class event_scoreboard #(int DEPTH = 8);
    typedef enum logic [1:0] {BTN_IDLE, BTN_PRESSED, BTN_WAIT, BTN_UNUSED} btn_phase_t;

    logic [15:0] db_ms, hold_ms, click_gap_ms, back_lockout_ms;
    logic [1:0]  last_ab;
    int          quarters;
    logic        sw_stable;
    logic [31:0] sw_change_ms;
    btn_phase_t  phase;
    logic [31:0] press_ms, release_ms;
    logic        long_fired;
    logic [1:0]  clicks;
    logic        back_was;
    logic [31:0] back_ms;
    logic [2:0]  ring [DEPTH];
    int unsigned head, tail;
    logic [2:0]  polled_events [$];
    int          errors;

    function new();
      db_ms = DEBOUNCE_RST;
      hold_ms = LONG_RST;
      click_gap_ms = GAP_RST;
      back_lockout_ms = LOCKOUT_RST;
      last_ab = AB_RST;
      quarters = 0;
      sw_stable = 1'b0;
      sw_change_ms = '0;
      phase = BTN_IDLE;
      press_ms = '0;
      release_ms = '0;
      long_fired = 1'b0;
      clicks = '0;
      back_was = 1'b1;
      back_ms = '0;
      foreach (ring[i]) ring[i] = EV_NONE;
      head = 0;
      tail = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_DEBOUNCE: db_ms = value;
        CFG_LONG:     hold_ms = value;
        CFG_GAP:      click_gap_ms = value;
        CFG_LOCKOUT:  back_lockout_ms = value;
        default: ;
      endcase
    endfunction

    // ring keeps one slot free, new events are dropped when full
    function void push_event(logic [2:0] code);
      int unsigned nxt;
      nxt = (tail + 1) % DEPTH;
      if (nxt != head) begin
        ring[tail] = code;
        tail = nxt;
      end
    endfunction

    function void flush_clicks();
      if (clicks != 2'd0) push_event(EV_CLICK1 + 3'(clicks - 2'd1));
      clicks = 2'd0;
    endfunction

    // gray code step: +1 along 00,10,11,01 and -1 the other way
    function int quarter_delta(logic [1:0] from_ab, logic [1:0] to_ab);
      case ({from_ab, to_ab})
        4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
        4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
        default: return 0;
      endcase
    endfunction

    function void start_press(logic [31:0] now);
      phase = BTN_PRESSED;
      press_ms = now;
      long_fired = 1'b0;
    endfunction

    // debounce and idle / pressed / wait-for-more-clicks machine
    function void button_tick(logic [31:0] now, logic sw_level);
      logic        raw;
      logic        held;
      logic [31:0] since;
      raw = !sw_level;
      if (raw != sw_stable) begin
        sw_stable = raw;
        sw_change_ms = now;
      end
      since = now - sw_change_ms;
      held = (since >= {16'd0, db_ms}) && sw_stable;
      case (phase)
        BTN_PRESSED: begin
          since = now - press_ms;
          if (!held) begin
            if (!long_fired) begin
              if (clicks != 2'd3) clicks = clicks + 2'd1;
              release_ms = now;
              phase = BTN_WAIT;
            end else begin
              phase = BTN_IDLE;
            end
          end else if (!long_fired && since >= {16'd0, hold_ms}) begin
            long_fired = 1'b1;
            clicks = 2'd0;
            push_event(EV_LONG);
          end
        end
        BTN_WAIT: begin
          since = now - release_ms;
          if (held) begin
            if (since >= {16'd0, click_gap_ms}) flush_clicks();
            start_press(now);
          end else if (since >= {16'd0, click_gap_ms}) begin
            flush_clicks();
            phase = BTN_IDLE;
          end
        end
        default: begin
          phase = BTN_IDLE;
          if (held) start_press(now);
        end
      endcase
    endfunction

    // an accepted input item
    function void note_item(logic [1:0] op, logic pin_a, logic pin_b, logic sw_level,
                            logic back_level, logic [31:0] now);
      logic [1:0]  ab;
      logic [31:0] since;
      case (op)
        OP_SAMPLE: begin
          ab = {pin_a, pin_b};
          quarters += quarter_delta(last_ab, ab);
          last_ab = ab;
          if (quarters > 32767) quarters = 32767;
          if (quarters < -32768) quarters = -32768;
        end
        OP_UPDATE: begin
          if (quarters >= 4 || quarters <= -4) begin
            push_event(quarters > 0 ? EV_CW : EV_CCW);
            quarters = quarters % 4;
          end
          button_tick(now, sw_level);
          since = now - back_ms;
          if (back_was && !back_level && since > {16'd0, back_lockout_ms}) begin
            push_event(EV_BACK);
            back_ms = now;
          end
          back_was = back_level;
        end
        OP_POLL: begin
          if (head != tail) begin
            polled_events.push_back(ring[head]);
            head = (head + 1) % DEPTH;
          end else begin
            polled_events.push_back(EV_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    // an accepted result item
    function void check_result(logic [2:0] got, time stamp);
      logic [2:0] want;
      if (polled_events.size() == 0) begin
        errors++;
        $display("%0t: result with no poll waiting, expected none, got event_code %0d",
                 stamp, got);
        return;
      end
      want = polled_events.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: event_code mismatch, expected %0d, got %0d", stamp, want, got);
      end
    endfunction

    function int pending();
      return polled_events.size();
    endfunction
  endclass

  localparam int RING_DEPTH = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int FAST_RUN = 40;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic        in_pin_a;
  logic        in_pin_b;
  logic        in_switch_level;
  logic        in_back_level;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_code;

  event_scoreboard #(RING_DEPTH) sb;

  bit          gaps_on = 1'b1;
  int          holdoff_asked = 0;
  int          items_sent = 0;
  int          cycle_count = 0;

  // stimulus state: encoder pins, switch and back levels, wall clock
  logic [1:0]  enc_ab;
  logic        sw_now;
  logic        back_now;
  logic [31:0] clock_ms;
  int unsigned tick_max;

  rotary_encoder_event_unit_top #(.QUEUE_SIZE(RING_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pin_a       (in_pin_a),
    .in_pin_b       (in_pin_b),
    .in_switch_level(in_switch_level),
    .in_back_level  (in_back_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin : result_sink
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_event_code, $time);
      @(negedge clk);
      if (holdoff_asked != served) begin
        served = holdoff_asked;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = gaps_on && ($urandom_range(99, 0) < 35);
      end
    end
  end

  // one input item, called and returning at a falling edge
  task automatic send_item(logic [1:0] op, logic a, logic b, logic sw, logic back,
                           logic [31:0] now);
    while (gaps_on && $urandom_range(99, 0) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_pin_a = a;
    in_pin_b = b;
    in_switch_level = sw;
    in_back_level = back;
    in_now_ms = now;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_item(op, a, b, sw, back, now);
    if (op != OP_IGNORED) items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic sample_ab(logic [1:0] ab);
    send_item(OP_SAMPLE, ab[1], ab[0], 1'($urandom), 1'($urandom), $urandom);
    enc_ab = ab;
  endtask

  // turn the encoder by n quarter-steps, optionally with glitches
  task automatic rotate(bit cw, int n, bit glitchy);
    logic [1:0] nxt;
    repeat (n) begin
      if (cw) begin
        case (enc_ab)
          2'b00: nxt = 2'b10;
          2'b10: nxt = 2'b11;
          2'b11: nxt = 2'b01;
          default: nxt = 2'b00;
        endcase
      end else begin
        case (enc_ab)
          2'b10: nxt = 2'b00;
          2'b11: nxt = 2'b10;
          2'b01: nxt = 2'b11;
          default: nxt = 2'b01;
        endcase
      end
      if (glitchy && $urandom_range(9, 0) == 0) nxt = enc_ab ^ 2'b11;
      else if (glitchy && $urandom_range(9, 0) == 0) nxt = enc_ab;
      sample_ab(nxt);
    end
  endtask

  task automatic tick();
    clock_ms = clock_ms + $urandom_range(tick_max, 1);
    send_item(OP_UPDATE, 1'($urandom), 1'($urandom), sw_now, back_now, clock_ms);
  endtask

  task automatic hold_for(int unsigned ms);
    logic [31:0] t0;
    t0 = clock_ms;
    do tick(); while (clock_ms - t0 < ms);
  endtask

  task automatic poll(int n);
    repeat (n) send_item(OP_POLL, 1'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), $urandom);
  endtask

  task automatic noise();
    logic [1:0] op;
    logic       a, b;
    op = 2'($urandom_range(3, 0));
    a = 1'($urandom);
    b = 1'($urandom);
    send_item(op, a, b, 1'($urandom), 1'($urandom), $urandom);
    if (op == OP_SAMPLE) enc_ab = {a, b};
  endtask

  // one to four presses: bounces, clicks and long presses
  task automatic click_gesture();
    int unsigned d, l, g, len;
    d = sb.db_ms;
    l = sb.hold_ms;
    g = sb.click_gap_ms;
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(3, 0) == 0) len = $urandom_range(d + l + 2 * tick_max, d + l);
      else len = $urandom_range(d + l, 0);
      sw_now = 1'b0;
      hold_for(len);
      sw_now = 1'b1;
      hold_for($urandom_range(2 * g + tick_max, 0));
    end
  endtask

  task automatic back_gesture();
    back_now = 1'b0;
    hold_for($urandom_range(2 * sb.back_lockout_ms + tick_max, 0));
    back_now = 1'b1;
    tick();
  endtask

  // wait for every result, then for the block to finish ring writes
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_timing(logic [15:0] d, logic [15:0] l, logic [15:0] g, logic [15:0] k);
    int unsigned m;
    settle();
    write_cfg(CFG_DEBOUNCE, d);
    write_cfg(CFG_LONG, l);
    write_cfg(CFG_GAP, g);
    write_cfg(CFG_LOCKOUT, k);
    m = d;
    if (l > m) m = l;
    if (g > m) m = g;
    if (k > m) m = k;
    tick_max = m / 6 + 1;
  endtask

  task automatic random_phase(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(9, 0))
        0, 1: rotate(1'($urandom), $urandom_range(12, 1), 1'b1);
        2, 3: click_gesture();
        4: back_gesture();
        5, 6: poll($urandom_range(3, 1));
        7: repeat ($urandom_range(3, 1)) tick();
        8: noise();
        default: begin
          rotate(1'($urandom), $urandom_range(12, 1), 1'b0);
          tick();
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operation = OP_SAMPLE;
    in_pin_a = 1'b1;
    in_pin_b = 1'b1;
    in_switch_level = 1'b1;
    in_back_level = 1'b1;
    in_now_ms = '0;
    enc_ab = AB_RST;
    sw_now = 1'b1;
    back_now = 1'b1;
    clock_ms = '0;
    tick_max = 20;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty poll, one cw detent, glitch, unknown op, back lockout,
    // single click, far time jump
    poll(1);
    sample_ab(2'b01);
    sample_ab(2'b00);
    sample_ab(2'b10);
    sample_ab(2'b11);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b1, 32'd10);
    poll(1);
    sample_ab(2'b00);
    send_item(OP_IGNORED, 1'b1, 1'b1, 1'b0, 1'b0, 32'hffff_ffff);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b0, 32'd100);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b1, 32'd110);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b0, 32'd120);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 1'b1, 32'd200);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 1'b1, 32'd230);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b1, 32'd260);
    send_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 1'b1, 32'd600);
    poll(2);
    send_item(OP_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, 32'hffff_ffff);
    poll(1);
    clock_ms = 32'hffff_ffff;

    // ring overflow, then a long receiver hold-off under a stream of polls
    repeat (10) begin
      rotate(1'b1, 4, 1'b0);
      tick();
    end
    holdoff_asked++;
    poll(40);

    // fast rotation in both directions, no idling
    gaps_on = 1'b0;
    rotate(1'b1, FAST_RUN, 1'b0);
    tick();
    poll(2);
    rotate(1'b0, FAST_RUN, 1'b0);
    tick();
    poll(2);
    gaps_on = 1'b1;

    // random traffic over several timing settings
    random_phase(200);
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    gaps_on = 1'b0;
    random_phase(300);
    gaps_on = 1'b1;
    set_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    random_phase(250);
    set_timing(16'($urandom_range(100, 0)), 16'($urandom_range(2000, 100)),
               16'($urandom_range(800, 50)), 16'($urandom_range(300, 0)));
    random_phase(300);
    set_timing(16'd1, 16'hffff, 16'd0, 16'hffff);
    random_phase(100);

    // drain and report
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/reeu_pkg.sv
hw/rtl/reeu_quad.sv
hw/rtl/reeu_button.sv
hw/rtl/reeu_queue.sv
hw/rtl/rotary_encoder_event_unit_top.sv
test/tb_rotary_encoder_event_unit_top.sv
